/* rtl/core/pid_controller_antiwindup_top_defines.svh */
// Assertion macros for the RTL files that check themselves.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PID_AW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid_aw: check failed");

// Next-cycle implication, checked outside reset.
`define PID_AW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid_aw: check failed");

`endif

/* rtl/core/pid_aw_pkg.sv */
`default_nettype none

package pid_aw_pkg;

  // Field and register widths.
  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int SUM_W   = 32;
  localparam int FRAC_W  = 8;

  // Sum limit divider: dividend is integ_limit scaled by 2^FRAC_W.
  localparam int DVD_W   = LIM_W + FRAC_W;
  localparam int DCNT_W  = $clog2(DVD_W + 1);

  // Shared multiplier: signed sum-width operand by zero-extended gain.
  localparam int MA_W    = SUM_W + 1;
  localparam int MB_W    = GAIN_W + 1;
  localparam int PROD_W  = MA_W + MB_W;

  // Configuration port.
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_INTEG_LIM  = 3'd3,
    REG_OUTPUT_LIM = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [GAIN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Adds a 17-bit signed value to the error sum, saturating at 32 bits.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [ERR_W:0]   b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W-ERR_W){b[ERR_W]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pid_aw_if.sv */
`default_nettype none

interface pid_aw_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pid_aw_pkg::ERR_W-1:0]   error_sample;
  logic                                  clear_history;

  modport source (output valid, output error_sample, output clear_history, input ready);
  modport sink   (input valid, input error_sample, input clear_history, output ready);
endinterface

interface pid_aw_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pid_aw_pkg::ERR_W-1:0]   drive_value;
  logic                                  limited;

  modport source (output valid, output drive_value, output limited, input ready);
  modport sink   (input valid, input drive_value, input limited, output ready);
endinterface

`default_nettype wire

/* rtl/core/pid_aw_div.sv */
`default_nettype none

module pid_aw_div
  import pid_aw_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [GAIN_W-1:0] rem_r;
  logic [GAIN_W-1:0] rem_nxt;
  logic [DVD_W-1:0]  dq_r;
  logic [GAIN_W-1:0] dsr_r;
  logic [GAIN_W:0]   shifted;
  logic [GAIN_W:0]   diff;
  logic              ge;

  // One restoring step per cycle: the dividend shifts out of dq_r at the
  // top while quotient bits shift in at the bottom.
  always_comb begin
    shifted = {rem_r, dq_r[DVD_W-1]};
    ge      = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = ge ? diff[GAIN_W-1:0] : shifted[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dq_r  <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[DVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

`default_nettype wire

/* rtl/core/pid_controller_antiwindup_top.sv */
// Positional PID controller with integral clamping and anti-windup, Q8.8.
// in_ch carries one word per control period: a signed Q8.8 error sample
// and a clear flag. out_ch returns one word per input word: the clamped
// drive value and a flag that tells whether the output limit was hit.
// Gains and limits are set through the APB-style cfg_ port (registers at
// byte addresses 0, 4, 8, 12, 16). The user must set them only while no
// word is in flight; the block itself does not enforce this. A normal
// word with a nonzero integral gain passes the sum update, the bit-serial
// divider that forms the sum limit (23 steps, then a done strobe), one
// clamp step, four steps through the shared multiplier and accumulator,
// one limit step and one output step. With zero integral gain the divider
// and the clamp step are skipped. A clear word goes straight to the output
// step. in_ch.ready is high only while the sequencer is idle, so no new
// word is accepted before the last one has left the sequencer.
// The result sits in an output register; the next input word is accepted
// while it waits. If the receiver stalls, the following result holds in the
// sequencer until the output register frees up.
// Reset clears the error sum and last error, sets the first-step flag (no
// derivative term on the next word), and restores the register defaults.
`include "pid_controller_antiwindup_top_defines.svh"
`default_nettype none

module pid_controller_antiwindup_top
  import pid_aw_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  pid_aw_in_if.sink          in_ch,
  pid_aw_out_if.source       out_ch,
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire  [CFG_AW-1:0]  cfg_paddr,
  input  wire  [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SUM   = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_CLAMP = 10'b00_0000_1000,
    S_MP    = 10'b00_0001_0000,
    S_MI    = 10'b00_0010_0000,
    S_MD    = 10'b00_0100_0000,
    S_ACC   = 10'b00_1000_0000,
    S_LIM   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [LIM_W-1:0]  integ_limit_r, output_limit_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // Controller state and working registers.
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [ERR_W-1:0]  prev_r;
  logic                     first_r;
  logic signed [ERR_W-1:0]  e_r;
  logic [DVD_W-1:0]         sl_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [ERR_W-1:0]  res_y_r;
  logic                     res_lim_r;

  // Output register.
  logic                     out_valid_r;
  logic signed [ERR_W-1:0]  out_y_r;
  logic                     out_lim_r;

  logic                     in_acc;
  logic                     out_free;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ERR_W:0]    e_ext;
  logic signed [ERR_W:0]    e_neg;
  logic signed [ERR_W:0]    e_diff;
  logic signed [SUM_W-1:0]  sl_s;
  logic signed [PROD_W-1:0] lim_full;
  logic signed [ERR_W-1:0]  olim_pos;
  logic signed [ERR_W-1:0]  olim_neg;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= '0;
      integ_gain_r   <= '0;
      deriv_gain_r   <= '0;
      integ_limit_r  <= '1;
      output_limit_r <= '1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_INTEG_LIM:  integ_limit_r  <= cfg_pwdata[LIM_W-1:0];
        REG_OUTPUT_LIM: output_limit_r <= cfg_pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:  cfg_prdata = CFG_DW'(prop_gain_r);
      REG_INTEG_GAIN: cfg_prdata = CFG_DW'(integ_gain_r);
      REG_DERIV_GAIN: cfg_prdata = CFG_DW'(deriv_gain_r);
      REG_INTEG_LIM:  cfg_prdata = CFG_DW'(integ_limit_r);
      REG_OUTPUT_LIM: cfg_prdata = CFG_DW'(output_limit_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sum limit divider
  // ---------------------------------------------------------------------
  assign div_req.start    = (state_r == S_SUM) && (integ_gain_r != '0);
  assign div_req.dividend = {integ_limit_r, {FRAC_W{1'b0}}};
  assign div_req.divisor  = integ_gain_r;

  pid_aw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign e_ext    = {e_r[ERR_W-1], e_r};
  assign e_neg    = -e_ext;
  assign e_diff   = e_ext - {prev_r[ERR_W-1], prev_r};
  assign sl_s     = {{(SUM_W-DVD_W){1'b0}}, sl_r};
  assign lim_full = {{(PROD_W-LIM_W-FRAC_W){1'b0}}, output_limit_r, {FRAC_W{1'b0}}};
  assign olim_pos = {1'b0, output_limit_r};
  assign olim_neg = -olim_pos;

  // Operand select for the shared multiplier. The derivative product is
  // forced to zero on the first step after reset or clear.
  always_comb begin
    case (state_r)
      S_MP: begin
        mul_a = {{(MA_W-ERR_W){e_r[ERR_W-1]}}, e_r};
        mul_b = {1'b0, prop_gain_r};
      end
      S_MI: begin
        mul_a = {sum_r[SUM_W-1], sum_r};
        mul_b = {1'b0, integ_gain_r};
      end
      S_MD: begin
        mul_a = {{(MA_W-ERR_W-1){e_diff[ERR_W]}}, e_diff};
        mul_b = first_r ? '0 : {1'b0, deriv_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = in_ch.clear_history ? S_DONE : S_SUM;
      S_SUM:   state_nxt = (integ_gain_r != '0) ? S_DIV : S_MP;
      S_DIV:   if (div_rsp.done) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_MP;
      S_MP:    state_nxt = S_MI;
      S_MI:    state_nxt = S_MD;
      S_MD:    state_nxt = S_ACC;
      S_ACC:   state_nxt = S_LIM;
      S_LIM:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      prev_r      <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.clear_history) begin
            sum_r   <= '0;
            prev_r  <= '0;
            first_r <= 1'b1;
          end
        end
        S_SUM: sum_r <= sat_add(sum_r, e_ext);
        S_CLAMP: begin
          if (sum_r > sl_s) begin
            sum_r <= sl_s;
          end else if (sum_r < -sl_s) begin
            sum_r <= -sl_s;
          end
        end
        S_LIM: begin
          // Anti-windup: a clamped output takes this sample back out.
          if ((acc_r > lim_full) || (acc_r < -lim_full)) begin
            sum_r <= sat_add(sum_r, e_neg);
          end
          prev_r  <= e_r;
          first_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r <= in_ch.error_sample;
    end
    if (in_acc && in_ch.clear_history) begin
      res_y_r   <= '0;
      res_lim_r <= 1'b0;
    end
    if (div_rsp.done) begin
      sl_r <= div_rsp.quotient;
    end
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_MI:  acc_r <= prod_r;
      S_MD:  acc_r <= acc_r + prod_r;
      S_ACC: acc_r <= acc_r + prod_r;
      default: ;
    endcase
    if (state_r == S_LIM) begin
      if (acc_r > lim_full) begin
        res_y_r   <= olim_pos;
        res_lim_r <= 1'b1;
      end else if (acc_r < -lim_full) begin
        res_y_r   <= olim_neg;
        res_lim_r <= 1'b1;
      end else begin
        // Arithmetic shift gives the floor of the Q34.16 total in Q8.8.
        res_y_r   <= acc_r[FRAC_W +: ERR_W];
        res_lim_r <= 1'b0;
      end
    end
    if ((state_r == S_DONE) && out_free) begin
      out_y_r   <= res_y_r;
      out_lim_r <= res_lim_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = out_y_r;
  assign out_ch.limited     = out_lim_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `PID_AW_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ch.ready)
  `PID_AW_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_r == S_DIV)
  `PID_AW_ASSERT_IMP(a_sum_within_limit, (state_r == S_MP) && (integ_gain_r != '0),
                     (sum_r <= sl_s) && (sum_r >= -sl_s))
  `PID_AW_ASSERT_IMP(a_limited_at_bound, out_valid_r && out_lim_r,
                     (out_y_r == olim_pos) || (out_y_r == olim_neg))

endmodule

`default_nettype wire

/* tb/pid_controller_antiwindup_top_tb.sv */
module pid_controller_antiwindup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pid_aw_pkg::*;

  localparam int NUM_REGS     = 5;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 122;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic signed [ERR_W-1:0] drive;
    logic                    limited;
  } drive_word_t;

  // Tracks the gains, the limits and the controller history, and predicts
  // the drive word for every accepted error sample.
  class drive_scoreboard;
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [LIM_W-1:0]  i_bound, out_bound;
    int                acc;
    int                last_err;
    bit                skip_deriv;
    drive_word_t       due[$];
    int                fails, checked, samples, clears;

    function new();
      fails = 0;
      checked = 0;
      samples = 0;
      clears = 0;
      kp = '0;
      ki = '0;
      kd = '0;
      i_bound = '1;
      out_bound = '1;
      acc = 0;
      last_err = 0;
      skip_deriv = 1'b1;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DW-1:0] v);
      case (idx)
        REG_PROP_GAIN:  kp = v[GAIN_W-1:0];
        REG_INTEG_GAIN: ki = v[GAIN_W-1:0];
        REG_DERIV_GAIN: kd = v[GAIN_W-1:0];
        REG_INTEG_LIM:  i_bound = v[LIM_W-1:0];
        REG_OUTPUT_LIM: out_bound = v[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CFG_DW-1:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_PROP_GAIN:  return CFG_DW'(kp);
        REG_INTEG_GAIN: return CFG_DW'(ki);
        REG_DERIV_GAIN: return CFG_DW'(kd);
        REG_INTEG_LIM:  return CFG_DW'(i_bound);
        REG_OUTPUT_LIM: return CFG_DW'(out_bound);
        default:        return '0;
      endcase
    endfunction

    function int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int waiting();
      return due.size();
    endfunction

    function void add_sample(logic signed [ERR_W-1:0] e_in, logic clr);
      longint      e, total, lim_full, sl;
      drive_word_t w;
      e = e_in;
      samples++;
      if (clr) begin
        clears++;
        acc = 0;
        last_err = 0;
        skip_deriv = 1'b1;
        w.drive = '0;
        w.limited = 1'b0;
        due.push_back(w);
        return;
      end
      acc = clip32(longint'(acc) + e);
      // With a nonzero integral gain the sum is held so that the integral
      // term stays within the integral limit.
      if (ki != 0) begin
        sl = (longint'(i_bound) << FRAC_W) / longint'(ki);
        if (acc > sl) acc = int'(sl);
        else if (acc < -sl) acc = int'(-sl);
      end
      total = e * longint'(kp) + longint'(acc) * longint'(ki);
      if (!skip_deriv) total += (e - longint'(last_err)) * longint'(kd);
      skip_deriv = 1'b0;
      last_err = int'(e);
      lim_full = longint'(out_bound) << FRAC_W;
      w.limited = 1'b0;
      if (total > lim_full) begin
        w.drive = ERR_W'(longint'(out_bound));
        w.limited = 1'b1;
      end else if (total < -lim_full) begin
        w.drive = ERR_W'(-longint'(out_bound));
        w.limited = 1'b1;
      end else begin
        w.drive = ERR_W'(total >>> FRAC_W);
      end
      // Anti-windup: a clamped step does not keep its sample in the sum.
      if (w.limited) acc = clip32(longint'(acc) - e);
      due.push_back(w);
    endfunction

    function void check_drive(logic signed [ERR_W-1:0] drive, logic limited);
      drive_word_t w;
      if (due.size() == 0) begin
        $error("unexpected drive word: drive_value %0d limited %0b", drive, limited);
        fails++;
        return;
      end
      w = due.pop_front();
      checked++;
      if (drive !== w.drive) begin
        $error("drive_value mismatch: expected %0d, got %0d", w.drive, drive);
        fails++;
      end
      if (limited !== w.limited) begin
        $error("limited mismatch: expected %0b, got %0b", w.limited, limited);
        fails++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pid_aw_in_if  in_ch();
  pid_aw_out_if out_ch();

  drive_scoreboard tracker;
  int              in_gap_max;
  int              out_gap_max;
  int              settings;

  pid_controller_antiwindup_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL pid_controller_antiwindup_top");
    $finish;
  end

  // Each APB transfer ends by dropping psel and waiting for the clock, so
  // that the next transfer starts in a later time step.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_reg(input reg_idx_t idx);
    logic [CFG_DW-1:0] got;
    logic [CFG_DW-1:0] want;
    cfg_read(CFG_AW'({idx, 2'b00}), got);
    want = tracker.reg_value(idx);
    if (got !== want) begin
      $error("%s readback mismatch: expected 0x%08h, got 0x%08h", idx.name(), want, got);
      tracker.fails++;
    end
  endtask

  task automatic check_all_regs();
    for (int i = 0; i < NUM_REGS; i++) verify_reg(reg_idx_t'(i));
  endtask

  task automatic program_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] v);
    cfg_write(CFG_AW'({idx, 2'b00}), v);
    tracker.set_reg(idx, v);
    verify_reg(idx);
  endtask

  // Upper data bits are random so that the register width masking is exercised.
  task automatic apply_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd, input logic [LIM_W-1:0] il,
                             input logic [LIM_W-1:0] ol);
    logic [CFG_DW-1:0] v;
    v = $urandom;
    v[GAIN_W-1:0] = kp;
    program_reg(REG_PROP_GAIN, v);
    v = $urandom;
    v[GAIN_W-1:0] = ki;
    program_reg(REG_INTEG_GAIN, v);
    v = $urandom;
    v[GAIN_W-1:0] = kd;
    program_reg(REG_DERIV_GAIN, v);
    v = $urandom;
    v[LIM_W-1:0] = il;
    program_reg(REG_INTEG_LIM, v);
    v = $urandom;
    v[LIM_W-1:0] = ol;
    program_reg(REG_OUTPUT_LIM, v);
    settings++;
  endtask

  task automatic send_sample(input logic signed [ERR_W-1:0] e, input logic clr);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.error_sample <= e;
    in_ch.clear_history <= clr;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    tracker.add_sample(e, clr);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(1, 63));
      3:       return GAIN_W'($urandom_range(64, 1024));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return LIM_W'($urandom_range(1, 255));
      default: return LIM_W'($urandom);
    endcase
  endfunction

  // A slowly moving error, as a loop under control would produce, mixed
  // with jumps to arbitrary values, to small values and to the extremes.
  function automatic logic signed [ERR_W-1:0] next_error(logic signed [ERR_W-1:0] prev);
    case ($urandom_range(0, 7))
      0, 1:    return ERR_W'($urandom);
      2:       return ERR_W'(int'($urandom_range(0, 511)) - 256);
      3:       return ERR_W'(int'($urandom_range(0, 8191)) - 4096);
      4:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      5:       return prev;
      default: return ERR_W'(int'(prev) + int'($urandom_range(0, 63)) - 32);
    endcase
  endfunction

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      tracker.check_drive(out_ch.drive_value, out_ch.limited);
    end
  end

  initial begin : stimulus
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] prev;
    logic                    clr;
    tracker = new();
    settings = 0;
    in_gap_max = 9;
    out_gap_max = 9;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.error_sample <= '0;
    in_ch.clear_history <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_all_regs();
    // With the reset gains every drive word is zero.
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);

    drain_results();
    apply_gains(16'h0100, 16'h0010, 16'h0080, 15'h0400, 15'h2000);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh0200, 1'b0);
    // A full-scale sample saturates the output and is taken back out of
    // the held sum, which swings the sum to the opposite side.
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh1234, 1'b1);
    send_sample(16'sh012C, 1'b0);
    send_sample(16'sh012C, 1'b0);

    // Zero output limit and zero integral limit with the largest gains.
    drain_results();
    apply_gains('1, '1, '1, '0, '0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);

    // Zero integral gain: the sum is never held.
    drain_results();
    apply_gains(16'h0001, '0, '1, '1, '1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      in_gap_max = (p == 1 || p == 3) ? 0 : 9;
      out_gap_max = (p == 1 || p == 2) ? 0 : 9;
      if (p == 0) apply_gains('1, '1, '1, '1, '1);
      else apply_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
      // A write past the last register must leave every register alone.
      cfg_write(CFG_AW'(4 * $urandom_range(NUM_REGS, (1 << CFG_AW) / 4 - 1)), $urandom);
      check_all_regs();
      prev = '0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        clr = ($urandom_range(0, 19) == 0);
        err = next_error(prev);
        send_sample(err, clr);
        prev = err;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d error samples (%0d clears) under %0d gain and limit settings;",
             tracker.samples, tracker.clears, settings);
    $display("%0d drive words were checked against the predicted values.", tracker.checked);
    if (tracker.fails == 0) begin
      $display("PASS pid_controller_antiwindup_top");
    end else begin
      $display("FAIL pid_controller_antiwindup_top");
    end
    $finish;
  end

endmodule

/* pid_controller_antiwindup_top.f */
+incdir+rtl/core
rtl/core/pid_aw_pkg.sv
rtl/core/pid_aw_if.sv
rtl/core/pid_aw_div.sv
rtl/core/pid_controller_antiwindup_top.sv
tb/pid_controller_antiwindup_top_tb.sv
